[rtl/mrf_pkg.sv]
`timescale 1ns / 1ps
// Package for the message ring FIFO: sizes, codes, transaction structs and
// the controller/datapath interface structs. No dependencies.
package mrf_pkg;

   localparam int SLOTS      = 128;
   localparam int SLOT_BYTES = 512;

   localparam int LEN_LIMIT = SLOT_BYTES - 2;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int COUNT_W   = $clog2(LEN_LIMIT + 1);
   localparam int ADDR_W    = $clog2(SLOTS * SLOT_BYTES);
   localparam int LEN_W     = 10;
   localparam int BYTE_W    = 8;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_READ  = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_WRITTEN  = 3'd0,
      STATUS_BAD_LEN  = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_READ     = 3'd3,
      STATUS_EMPTY    = 3'd4,
      STATUS_TOO_LONG = 3'd5
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [BYTE_W-1:0]  data_byte;
      logic               final_byte;
      logic [LEN_W-1:0]   max_length;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  read_byte;
      logic [LEN_W-1:0]   message_length;
      logic               read_last;
   } rsp_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_result;
      logic out_free;
   } dp_status_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
      return r;
   endfunction

endpackage

[rtl/mrf_ctrl.sv]
`timescale 1ns / 1ps
// Message ring FIFO controller: accept/execute sequencing.
// Depends on mrf_pkg.
module mrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mrf_pkg::dp_status_type dp_status,
   output mrf_pkg::ctrl_cmd_type  cmd
);
   import mrf_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            // hold while a result is due and the output register is occupied and stalled
            if (!dp_status.need_result || dp_status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

[rtl/mrf_dpath.sv]
`timescale 1ns / 1ps
// Message ring FIFO datapath: slot pointers, byte store, length table and
// output register. Depends on mrf_pkg.
module mrf_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  mrf_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mrf_pkg::rsp_type       rsp_data,
   input  mrf_pkg::ctrl_cmd_type  cmd,
   output mrf_pkg::dp_status_type dp_status
);
   import mrf_pkg::*;

   logic [BYTE_W-1:0] byte_mem [SLOTS*SLOT_BYTES];
   logic [LEN_W-1:0]  len_mem  [SLOTS];

   req_type            item_ff;
   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [COUNT_W-1:0] write_count_ff, write_count_in;
   logic [COUNT_W-1:0] read_offset_ff, read_offset_in;
   logic [BYTE_W-1:0]  byte_rdata_ff;
   logic [LEN_W-1:0]   len_rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               byte_we;
   logic               len_we;
   logic               stores;
   logic [COUNT_W-1:0] count_inc;
   logic [SLOT_W-1:0]  ws_next;
   logic [SLOT_W-1:0]  rs_next;
   logic               empty;
   logic               full;
   logic               rd_last;
   logic               need_result;
   logic               out_free;

   assign wr_addr = ADDR_W'(write_slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(write_count_ff);
   assign rd_addr = ADDR_W'(read_slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_offset_ff);

   assign stores    = write_count_ff < COUNT_W'(LEN_LIMIT);
   assign count_inc = stores ? write_count_ff + 1'b1 : write_count_ff;
   assign ws_next   = next_slot(write_slot_ff);
   assign rs_next   = next_slot(read_slot_ff);
   assign empty     = read_slot_ff == write_slot_ff;
   assign full      = ws_next == read_slot_ff;
   assign rd_last   = ({1'b0, LEN_W'(read_offset_ff)} + 1'b1) >= {1'b0, len_rdata_ff};

   assign need_result = (item_ff.mode == MODE_READ) || item_ff.final_byte;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign dp_status.need_result = need_result;
   assign dp_status.out_free    = out_free;

   always_comb begin
      write_slot_in  = write_slot_ff;
      read_slot_in   = read_slot_ff;
      write_count_in = write_count_ff;
      read_offset_in = read_offset_ff;
      byte_we        = 1'b0;
      len_we         = 1'b0;
      rsp_data_in    = '{status: STATUS_EMPTY, read_byte: '0, message_length: '0,
                         read_last: 1'b0};
      if (item_ff.mode == MODE_WRITE) begin
         byte_we        = cmd.execute && stores;
         write_count_in = count_inc;
         rsp_data_in.message_length = LEN_W'(count_inc);
         if (item_ff.final_byte) begin
            write_count_in = '0;
            if (count_inc >= COUNT_W'(LEN_LIMIT)) begin
               rsp_data_in.status = STATUS_BAD_LEN;
            end else if (full) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.status = STATUS_WRITTEN;
               len_we             = cmd.execute;
               write_slot_in      = ws_next;
            end
         end
      end else if (!empty) begin
         rsp_data_in.message_length = len_rdata_ff;
         if (len_rdata_ff > item_ff.max_length) begin
            rsp_data_in.status = STATUS_TOO_LONG;
         end else begin
            rsp_data_in.status    = STATUS_READ;
            rsp_data_in.read_byte = byte_rdata_ff;
            rsp_data_in.read_last = rd_last;
            if (rd_last) begin
               read_offset_in = '0;
               read_slot_in   = rs_next;
            end else begin
               read_offset_in = read_offset_ff + 1'b1;
            end
         end
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.execute && need_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[wr_addr] <= item_ff.data_byte;
      end
      byte_rdata_ff <= byte_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[write_slot_ff] <= LEN_W'(count_inc);
      end
      len_rdata_ff <= len_mem[read_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.execute && need_result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff  <= '0;
         read_slot_ff   <= '0;
         write_count_ff <= '0;
         read_offset_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            write_slot_ff  <= write_slot_in;
            read_slot_ff   <= read_slot_in;
            write_count_ff <= write_count_in;
            read_offset_ff <= read_offset_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      write_count_ff <= COUNT_W'(LEN_LIMIT))
      else $error("write count beyond length limit");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> $stable(write_count_ff) && $stable(read_slot_ff)
         && $stable(write_slot_ff) && $stable(read_offset_ff))
      else $error("pointer moved without execute");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && need_result && rsp_data_in.status == STATUS_READ
         && rsp_data_in.read_last |=> read_offset_ff == '0)
      else $error("read offset not cleared after last byte");

   a_exec_loads_out: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && need_result |=> rsp_valid_ff)
      else $error("result lost");
`endif

endmodule

[rtl/message_ring_fifo.sv]
`timescale 1ns / 1ps
// Message ring FIFO top level: controller plus datapath.
// Depends on mrf_pkg, mrf_ctrl and mrf_dpath.
// Each transaction has an accept cycle, in which the byte
// store and length table are read at the current read position, and an
// execute cycle that updates the pointers and loads the output register.
// Execution waits while a result is due and the output register is still
// held by rsp_stall. Non-final write bytes give no result. The stores have
// no reset and need no clearing pass; the ring holds SLOTS-1 messages of
// up to SLOT_BYTES-3 bytes each.
module message_ring_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mrf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mrf_pkg::rsp_type rsp_data
);
   import mrf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   mrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   mrf_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

endmodule

[tb/message_ring_fifo_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for message_ring_fifo: directed and random message traffic,
// checked against a behavioural ring model kept in step with accepted transactions.
// Depends on mrf_pkg and the message_ring_fifo RTL.
module message_ring_fifo_test;
   import mrf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   message_ring_fifo uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_type req_backlog[$];
   rsp_type results_due[$];
   int      items_queued = 0;
   int      results_seen = 0;
   int      mismatch_count = 0;
   logic    req_taken = 1'b0;
   logic    rsp_taken = 1'b0;

   // ring model state
   logic [7:0] msg_store [SLOTS*SLOT_BYTES];
   int         msg_len_tbl [SLOTS];
   int         wr_slot = 0;
   int         rd_slot = 0;
   int         fill_count = 0;
   int         rd_offset = 0;

   function automatic int ring_next(input int s);
      return (s + 1 >= SLOTS) ? 0 : s + 1;
   endfunction

   task automatic predict_ring_result(input req_type t);
      rsp_type r;
      int      len;
      r = '0;
      if (t.mode == MODE_WRITE) begin
         if (fill_count < LEN_LIMIT) begin
            msg_store[wr_slot*SLOT_BYTES + fill_count] = t.data_byte;
            fill_count++;
         end
         if (!t.final_byte) return;
         len = fill_count;
         fill_count = 0;
         r.message_length = LEN_W'(len);
         if (len >= LEN_LIMIT) r.status = STATUS_BAD_LEN;
         else if (ring_next(wr_slot) == rd_slot) r.status = STATUS_FULL;
         else begin
            msg_len_tbl[wr_slot] = len;
            wr_slot = ring_next(wr_slot);
            r.status = STATUS_WRITTEN;
         end
      end else if (rd_slot == wr_slot) begin
         r.status = STATUS_EMPTY;
      end else begin
         len = msg_len_tbl[rd_slot];
         r.message_length = LEN_W'(len);
         if (len > t.max_length) r.status = STATUS_TOO_LONG;
         else begin
            r.status = STATUS_READ;
            r.read_byte = msg_store[rd_slot*SLOT_BYTES + rd_offset];
            r.read_last = (rd_offset + 1 >= len);
            if (r.read_last) begin
               rd_offset = 0;
               rd_slot = ring_next(rd_slot);
            end else begin
               rd_offset++;
            end
         end
      end
      results_due.push_back(r);
   endtask

   function automatic void report_field(input string field, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      mismatch_count++;
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (results_due.size() == 0) begin
         $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
         mismatch_count++;
         return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status)
         report_field("status", 16'(want.status), 16'(got.status));
      if (got.read_byte !== want.read_byte)
         report_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
      if (got.message_length !== want.message_length)
         report_field("message_length", 16'(want.message_length), 16'(got.message_length));
      if (got.read_last !== want.read_last)
         report_field("read_last", 16'(want.read_last), 16'(got.read_last));
   endtask

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) predict_ring_result(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         check_result(rsp_data);
      end
   end

   // sender
   int   req_gap = 0;
   logic req_quiet = 1'b0;

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (req_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
            if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
            req_gap = req_quiet ? 0 : $urandom_range(0, 14);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off now and then to back the block up
   int   rsp_wait = 0;
   logic rsp_quiet = 1'b0;

   always @(negedge clock) begin
      if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         if (results_seen % 1000 == 200) rsp_wait = LONG_HOLD;
         else rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 14);
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void queue_item(input mode_type m, input logic [7:0] d,
                                      input logic f, input logic [9:0] ml);
      req_type t;
      t.mode = m;
      t.data_byte = d;
      t.final_byte = f;
      t.max_length = ml;
      req_backlog.push_back(t);
      items_queued++;
   endfunction

   function automatic void queue_message(input int len);
      for (int i = 0; i < len; i++)
         queue_item(MODE_WRITE, 8'($urandom), i == len - 1, 10'($urandom_range(0, 1023)));
   endfunction

   function automatic void queue_reads(input int n, input logic [9:0] ml);
      for (int i = 0; i < n; i++) queue_item(MODE_READ, 8'($urandom), 1'($urandom), ml);
   endfunction

   initial begin
      int         pick;
      int         n;
      logic [9:0] burst_max;

      // directed
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd0);
      queue_item(MODE_WRITE, 8'h00, 1'b1, 10'd1023);
      queue_item(MODE_WRITE, 8'hFF, 1'b1, 10'd0);
      queue_item(MODE_READ, 8'hFF, 1'b1, 10'd0);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd1);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd1023);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd1023);
      queue_item(MODE_WRITE, 8'hA5, 1'b0, 10'd0);
      queue_item(MODE_WRITE, 8'h5A, 1'b0, 10'd1023);
      queue_item(MODE_WRITE, 8'h3C, 1'b1, 10'd0);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd2);
      queue_reads(3, 10'd3);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd3);
      queue_item(MODE_WRITE, 8'h80, 1'b0, 10'd512);
      queue_item(MODE_WRITE, 8'h01, 1'b1, 10'd512);
      queue_item(MODE_WRITE, 8'h7F, 1'b1, 10'd512);
      queue_reads(4, 10'd1023);

      // fill the ring, overflow it, then drain
      for (int i = 0; i < SLOTS - 1; i++) queue_message(1);
      queue_message(1);
      queue_message(4);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'd0);
      queue_reads(SLOTS, 10'd1023);

      // longest legal message, then an over-length one
      queue_message(LEN_LIMIT - 1);
      queue_item(MODE_READ, 8'h00, 1'b0, 10'(LEN_LIMIT - 2));
      queue_reads(LEN_LIMIT - 1, 10'(LEN_LIMIT - 1));
      queue_message(LEN_LIMIT + 3);
      queue_reads(1, 10'd1023);

      // random traffic
      while (items_queued < 2000) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            queue_message(pick < 4 ? $urandom_range(13, 60) : $urandom_range(1, 12));
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: burst_max = 10'($urandom_range(0, 15));
               1: burst_max = 10'($urandom_range(0, 1023));
               default: burst_max = 10'd1023;
            endcase
            queue_reads($urandom_range(1, 16), burst_max);
         end else if (pick < 90) begin
            queue_item(mode_type'(1'($urandom)), 8'($urandom), 1'($urandom),
                       10'($urandom_range(0, 1023)));
         end else begin
            // reads arriving part way through a message
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               queue_item(MODE_WRITE, 8'($urandom), 1'b0, 10'($urandom_range(0, 1023)));
            queue_reads($urandom_range(1, 4), 10'd1023);
            queue_message($urandom_range(1, 6));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(negedge clock);
      while (results_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

endmodule
